// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/fcov_pkg.sv -----
package fcov_pkg;

   localparam int NUM_CHROMS    = 24;
   localparam int MAX_POSITIONS = 65536;
   localparam int COUNT_WIDTH   = 32;

   localparam int CHROM_WIDTH = 5;
   localparam int POS_WIDTH   = 16;
   localparam int LEN_WIDTH   = 14;
   localparam int QUAL_WIDTH  = 8;

   localparam int STORE_DEPTH = NUM_CHROMS * MAX_POSITIONS;
   localparam int ADDR_WIDTH  = $clog2(STORE_DEPTH);

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = LEN_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MIN_FRAG_LEN  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAX_FRAG_LEN  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUALITY_FLOOR = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COUNT_ENDS    = 2'd3;

   typedef enum logic {
      ACTION_ADD  = 1'b0,
      ACTION_READ = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_DONE         = 2'd0,
      STATUS_FILTERED     = 2'd1,
      STATUS_BAD_CHROM    = 2'd2,
      STATUS_OUT_OF_RANGE = 2'd3
   } status_type;

   // Flat store address of one position on one chromosome.
   function automatic logic [ADDR_WIDTH-1:0] cell_addr(
      input logic [CHROM_WIDTH-1:0] chrom,
      input logic [POS_WIDTH-1:0]   pos
   );
      cell_addr = ADDR_WIDTH'(chrom) * ADDR_WIDTH'(MAX_POSITIONS) + ADDR_WIDTH'(pos);
   endfunction

   // Add one unless the counter is already at its maximum.
   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] count);
      sat_inc = (&count) ? count : count + COUNT_WIDTH'(1);
   endfunction

endpackage

// ----- rtl/fcov_ram.sv -----
module fcov_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/fragment_coverage_accumulator_core.sv -----
// Fragment coverage accumulator.
// The req channel takes one item at a time: tuser holds the action (add or
// read), tdata the chromosome, start, end and mapping quality. Every item
// gives one item on the rsp channel: tuser holds the status, tdata the
// coverage, start and end counts (all zero for adds and rejected reads).
// A read or a rejected add passes to the finish state, which registers its result
// once the output register is free; only then does the block take the next item.
// An accepted add walks the coverage memory, which also holds the start
// counts, one position a cycle with a read-modify-write, so it occupies the
// block for its whole length (one read more for a zero-length fragment
// whose ends are counted) and shows its result in the cycle the block frees;
// the coverage memory has a single read port and a single write port.
// After reset the block sweeps both memories to zero, one entry a
// cycle, over all 1572864 entries; req_tready stays low meanwhile, while csr
// writes are taken at any time.
// A result waits in an output register while rsp_tready is low; the block
// still takes and works on the next item, and holds that one's result
// until the register frees.
module fragment_coverage_accumulator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // chrom_index, frag_start, frag_end, map_quality
   input  logic [0:0]  req_tuser,  // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,  // coverage_count, start_count, end_count
   output logic [1:0]  rsp_tuser,  // status
   input  logic        csr_we,
   input  logic [fcov_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [fcov_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int AW = fcov_pkg::ADDR_WIDTH;
   localparam int CW = fcov_pkg::COUNT_WIDTH;
   localparam int PW = fcov_pkg::POS_WIDTH;
   localparam int LW = fcov_pkg::LEN_WIDTH;
   localparam int QW = fcov_pkg::QUAL_WIDTH;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SWEEP  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // Configuration registers.
   logic [LW-1:0] min_len_ff, min_len_in;
   logic [LW-1:0] max_len_ff, max_len_in;
   logic [QW-1:0] qual_floor_ff, qual_floor_in;
   logic          count_ends_ff, count_ends_in;

   // Control.
   state_type     state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          ends_pending_ff, ends_pending_in;
   logic          cov_wb_ff, cov_wb_in;
   logic          end_wb_ff, end_wb_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Item payload.
   logic [AW-1:0]        cov_addr_ff, cov_addr_in;
   logic [AW-1:0]        cov_wb_addr_ff, cov_wb_addr_in;
   logic                 cov_inc_ff, cov_inc_in;
   logic                 start_inc_ff, start_inc_in;
   logic [AW-1:0]        end_addr_ff, end_addr_in;
   logic [LW-1:0]        remain_ff, remain_in;
   fcov_pkg::status_type status_ff, status_in;
   logic                 read_hit_ff, read_hit_in;
   fcov_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [31:0]          rsp_cov_ff, rsp_cov_in;
   logic [31:0]          rsp_start_ff, rsp_start_in;
   logic [31:0]          rsp_end_ff, rsp_end_in;

   // Input fields.
   fcov_pkg::action_type             req_action;
   logic [fcov_pkg::CHROM_WIDTH-1:0] req_chrom;
   logic [PW-1:0]                req_start;
   logic [PW-1:0]                req_end;
   logic [QW-1:0]                req_qual;

   logic                 req_accept;
   logic [PW:0]          frag_len_wide;
   logic [PW:0]          start_plus;
   logic                 length_ok;
   logic                 qual_ok;
   logic                 chrom_ok;
   logic                 add_pos_ok;
   logic                 read_pos_ok;
   fcov_pkg::status_type req_status;
   logic [AW-1:0]        read_addr;
   logic [AW-1:0]        first_addr;
   logic                 rsp_free;

   // Memory ports. The coverage memory keeps the coverage count in its lower
   // half and the start count in its upper half.
   logic            cov_rd_en, end_rd_en;
   logic [AW-1:0]   cov_rd_addr, end_rd_addr;
   logic [2*CW-1:0] cov_rd_data;
   logic [CW-1:0]   end_rd_data;
   logic [CW-1:0]   cov_rd_count, start_rd_count;
   logic            clearing;
   logic            cov_wr_en, end_wr_en;
   logic [AW-1:0]   cov_wr_addr, end_wr_addr;
   logic [2*CW-1:0] cov_wr_data;
   logic [CW-1:0]   end_wr_data;

   assign req_action = fcov_pkg::action_type'(req_tuser[0]);
   assign req_chrom  = req_tdata[4:0];
   assign req_start  = req_tdata[20:5];
   assign req_end    = req_tdata[36:21];
   assign req_qual   = req_tdata[44:37];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Screening of the incoming item.
   always_comb begin
      frag_len_wide = {1'b0, req_end} - {1'b0, req_start};
      start_plus    = {1'b0, req_start} + (PW+1)'(1);
      length_ok     = !frag_len_wide[PW]
                      && (frag_len_wide[PW-1:0] >= PW'(min_len_ff))
                      && (frag_len_wide[PW-1:0] <= PW'(max_len_ff));
      qual_ok       = req_qual > qual_floor_ff;
      chrom_ok      = 32'(req_chrom) < 32'(fcov_pkg::NUM_CHROMS);
      add_pos_ok    = (32'(start_plus) < 32'(fcov_pkg::MAX_POSITIONS))
                      && (32'(req_end) < 32'(fcov_pkg::MAX_POSITIONS));
      read_pos_ok   = 32'(req_start) < 32'(fcov_pkg::MAX_POSITIONS);

      if (req_action == fcov_pkg::ACTION_READ) begin
         if (!chrom_ok) begin
            req_status = fcov_pkg::STATUS_BAD_CHROM;
         end else if (!read_pos_ok) begin
            req_status = fcov_pkg::STATUS_OUT_OF_RANGE;
         end else begin
            req_status = fcov_pkg::STATUS_DONE;
         end
      end else begin
         if (!(qual_ok && length_ok)) begin
            req_status = fcov_pkg::STATUS_FILTERED;
         end else if (!chrom_ok) begin
            req_status = fcov_pkg::STATUS_BAD_CHROM;
         end else if (!add_pos_ok) begin
            req_status = fcov_pkg::STATUS_OUT_OF_RANGE;
         end else begin
            req_status = fcov_pkg::STATUS_DONE;
         end
      end

      read_addr  = fcov_pkg::cell_addr(req_chrom, req_start);
      first_addr = fcov_pkg::cell_addr(req_chrom, start_plus[PW-1:0]);
   end

   // Configuration writes.
   always_comb begin
      min_len_in    = min_len_ff;
      max_len_in    = max_len_ff;
      qual_floor_in = qual_floor_ff;
      count_ends_in = count_ends_ff;
      if (csr_we) begin
         unique case (csr_index)
            fcov_pkg::REG_MIN_FRAG_LEN:  min_len_in    = csr_wdata[LW-1:0];
            fcov_pkg::REG_MAX_FRAG_LEN:  max_len_in    = csr_wdata[LW-1:0];
            fcov_pkg::REG_QUALITY_FLOOR: qual_floor_in = csr_wdata[QW-1:0];
            fcov_pkg::REG_COUNT_ENDS:    count_ends_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cov_rd_count   = cov_rd_data[CW-1:0];
   assign start_rd_count = cov_rd_data[2*CW-1:CW];

   // Sequencer.
   always_comb begin
      state_in        = state_ff;
      clr_addr_in     = clr_addr_ff;
      ends_pending_in = ends_pending_ff;
      cov_addr_in     = cov_addr_ff;
      end_addr_in     = end_addr_ff;
      remain_in       = remain_ff;
      status_in       = status_ff;
      read_hit_in     = read_hit_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_cov_in      = rsp_cov_ff;
      rsp_start_in    = rsp_start_ff;
      rsp_end_in      = rsp_end_ff;
      rsp_valid_in    = rsp_tready ? 1'b0 : rsp_valid_ff;

      cov_rd_en   = 1'b0;
      end_rd_en   = 1'b0;
      cov_rd_addr = read_addr;
      end_rd_addr = read_addr;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(fcov_pkg::STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               status_in     = req_status;
               read_hit_in   = (req_action == fcov_pkg::ACTION_READ)
                               && (req_status == fcov_pkg::STATUS_DONE);
               cov_addr_in   = first_addr;
               end_addr_in   = fcov_pkg::cell_addr(req_chrom, req_end);
               remain_in     = frag_len_wide[LW-1:0];
               if (read_hit_in) begin
                  cov_rd_en = 1'b1;
                  end_rd_en = 1'b1;
               end
               if ((req_action == fcov_pkg::ACTION_ADD)
                   && (req_status == fcov_pkg::STATUS_DONE)) begin
                  ends_pending_in = count_ends_ff;
                  state_in        = ST_SWEEP;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SWEEP: begin
            // One coverage read per cycle; the write of the previous position
            // goes back in the same cycle from the pipeline register. With end
            // counting on, the first read also bumps the start count, and it
            // still happens for a zero-length fragment.
            if ((remain_ff != '0) || ends_pending_ff) begin
               cov_rd_en   = 1'b1;
               cov_rd_addr = cov_addr_ff;
            end
            if (remain_ff != '0) begin
               cov_addr_in = cov_addr_ff + AW'(1);
               remain_in   = remain_ff - LW'(1);
            end
            if (ends_pending_ff) begin
               end_rd_en       = 1'b1;
               end_rd_addr     = end_addr_ff;
               ends_pending_in = 1'b0;
            end
            if ((remain_ff == '0) && !ends_pending_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_cov_in    = read_hit_ff ? 32'(cov_rd_count) : '0;
               rsp_start_in  = read_hit_ff ? 32'(start_rd_count) : '0;
               rsp_end_in    = read_hit_ff ? 32'(end_rd_data) : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      cov_wb_in      = cov_rd_en && (state_ff == ST_SWEEP);
      cov_wb_addr_in = cov_addr_ff;
      cov_inc_in     = (remain_ff != '0);
      start_inc_in   = ends_pending_ff;
      end_wb_in      = end_rd_en && (state_ff == ST_SWEEP);
   end

   // Write side: zero sweep after reset, otherwise saturating write-back.
   assign clearing    = (state_ff == ST_CLEAR);
   assign cov_wr_en   = clearing || cov_wb_ff;
   assign cov_wr_addr = clearing ? clr_addr_ff : cov_wb_addr_ff;
   assign cov_wr_data = clearing ? '0 :
                        {(start_inc_ff ? fcov_pkg::sat_inc(start_rd_count) : start_rd_count),
                         (cov_inc_ff ? fcov_pkg::sat_inc(cov_rd_count) : cov_rd_count)};
   assign end_wr_en   = clearing || end_wb_ff;
   assign end_wr_addr = clearing ? clr_addr_ff : end_addr_ff;
   assign end_wr_data = clearing ? '0 : fcov_pkg::sat_inc(end_rd_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_addr_ff     <= '0;
         ends_pending_ff <= 1'b0;
         cov_wb_ff       <= 1'b0;
         end_wb_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         min_len_ff      <= LW'(120);
         max_len_ff      <= LW'(180);
         qual_floor_ff   <= QW'(30);
         count_ends_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_addr_ff     <= clr_addr_in;
         ends_pending_ff <= ends_pending_in;
         cov_wb_ff       <= cov_wb_in;
         end_wb_ff       <= end_wb_in;
         rsp_valid_ff    <= rsp_valid_in;
         min_len_ff      <= min_len_in;
         max_len_ff      <= max_len_in;
         qual_floor_ff   <= qual_floor_in;
         count_ends_ff   <= count_ends_in;
      end
   end

   always_ff @(posedge clock) begin
      cov_addr_ff    <= cov_addr_in;
      cov_wb_addr_ff <= cov_wb_addr_in;
      cov_inc_ff     <= cov_inc_in;
      start_inc_ff   <= start_inc_in;
      end_addr_ff    <= end_addr_in;
      remain_ff      <= remain_in;
      status_ff      <= status_in;
      read_hit_ff    <= read_hit_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_cov_ff     <= rsp_cov_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_end_ff     <= rsp_end_in;
   end

   fcov_ram #(.WIDTH(2 * CW), .DEPTH(fcov_pkg::STORE_DEPTH)) u_cov_ram (
      .clock   (clock),
      .wr_en   (cov_wr_en),
      .wr_addr (cov_wr_addr),
      .wr_data (cov_wr_data),
      .rd_en   (cov_rd_en),
      .rd_addr (cov_rd_addr),
      .rd_data (cov_rd_data)
   );

   fcov_ram #(.WIDTH(CW), .DEPTH(fcov_pkg::STORE_DEPTH)) u_end_ram (
      .clock   (clock),
      .wr_en   (end_wr_en),
      .wr_addr (end_wr_addr),
      .wr_data (end_wr_data),
      .rd_en   (end_rd_en),
      .rd_addr (end_rd_addr),
      .rd_data (end_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_end_ff, rsp_start_ff, rsp_cov_ff};

endmodule

// ----- rtl/fcov_checker.sv -----
`include "assert_macros.svh"

module fcov_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,  // coverage_count, start_count, end_count
   input logic [1:0]  rsp_tuser   // status
);

   logic [1:0] pending_ff, pending_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // Items taken whose result has not yet been delivered.
   always_comb begin
      pending_in = pending_ff + 2'(req_fire) - 2'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // The zero sweep starts at reset: no item is taken and no result shows.
   `ASSERT_NXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_tvalid && !req_tready, "busy after reset")

   // A result held by the receiver keeps its value.
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // Any status other than done carries zero counts.
   `ASSERT_IMP(a_error_zero, clock, reset, rsp_tvalid && (rsp_tuser != fcov_pkg::STATUS_DONE), rsp_tdata == '0, "error result with counts")

   // At most one item in work and one result waiting; never a result
   // without an item behind it.
   `ASSERT_IMP(a_pending_bound, clock, reset, rsp_tvalid || req_fire, (pending_ff <= 2'd2) && (!rsp_tvalid || (pending_ff != 2'd0)), "result count mismatch")

endmodule

bind fragment_coverage_accumulator_core fcov_checker u_fcov_checker (.*);
